>>> design/cpm_pkg.sv
// ----------------------------------------------------------------------------
// cpm_pkg
// Shared types, register indexes and the case-folding helper for the
// caseless pattern match positions unit.
// ----------------------------------------------------------------------------
package cpm_pkg;

   localparam int unsigned TEXT_W  = 8;
   localparam int unsigned LENREG_W = 5;
   localparam int unsigned PAT_W   = 128;
   localparam int unsigned LIMIT_W = 16;
   localparam int unsigned POS_W   = 20;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [TEXT_W-1:0] NUL_CHAR = 8'h00;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LENGTH = 2'd0,
      CSR_PATTERN_LOW    = 2'd1,
      CSR_PATTERN_HIGH   = 2'd2,
      CSR_MATCH_LIMIT    = 2'd3
   } cpm_csr_index_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [LENREG_W-1:0] pattern_length;
      logic [PAT_W-1:0]    pattern;
      logic [LIMIT_W-1:0]  match_limit;
   } cpm_cfg_type;

   // ASCII upper-case letters map to lower case; all other codes pass.
   function automatic logic [TEXT_W-1:0] cpm_fold(input logic [TEXT_W-1:0] c);
      logic [TEXT_W-1:0] r;
      r = c;
      if (c inside {[8'h41:8'h5A]}) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

>>> design/cpm_if.sv
// ----------------------------------------------------------------------------
// cpm_if
// Channel interfaces: byte request, match response and register write.
// ----------------------------------------------------------------------------
interface cpm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       first_byte;
   logic       last_byte;

   modport source (output valid, output text_byte, output first_byte,
                   output last_byte, input ready);
   modport sink   (input valid, input text_byte, input first_byte,
                   input last_byte, output ready);
endinterface

interface cpm_rsp_if;
   logic        valid;
   logic        ready;
   logic        match_found;
   logic [19:0] match_position;
   logic        scan_done;
   logic [15:0] match_total;

   modport source (output valid, output match_found, output match_position,
                   output scan_done, output match_total, input ready);
   modport sink   (input valid, input match_found, input match_position,
                   input scan_done, input match_total, output ready);
endinterface

interface cpm_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/cpm_csr.sv
// ----------------------------------------------------------------------------
// cpm_csr
// Configuration registers: pattern length, pattern bytes and match limit.
// ----------------------------------------------------------------------------
module cpm_csr (
   input  logic                clock,
   input  logic                reset,
   cpm_csr_if.sink             csr,
   output cpm_pkg::cpm_cfg_type cfg
);
   import cpm_pkg::*;

   cpm_cfg_type cfg_ff;
   cpm_cfg_type cfg_in;

   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (cpm_csr_index_type'(csr.index))
            CSR_PATTERN_LENGTH: cfg_in.pattern_length = csr.data[LENREG_W-1:0];
            CSR_PATTERN_LOW:    cfg_in.pattern[63:0]  = csr.data;
            CSR_PATTERN_HIGH:   cfg_in.pattern[127:64] = csr.data;
            CSR_MATCH_LIMIT:    cfg_in.match_limit    = csr.data[LIMIT_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/cpm_window_cmp.sv
// ----------------------------------------------------------------------------
// cpm_window_cmp
// Parallel caseless compare of the newest bytes against the pattern.
// ----------------------------------------------------------------------------
module cpm_window_cmp #(
   parameter int unsigned PATTERN_MAX = 16,
   parameter int unsigned LEN_W       = 5
) (
   input  logic [PATTERN_MAX-1:0][7:0] window,
   input  logic [cpm_pkg::PAT_W-1:0]   pattern,
   input  logic [LEN_W-1:0]            len,
   output logic                        equal
);
   import cpm_pkg::*;

   localparam int unsigned IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   logic mismatch;

   // Pattern byte i lines up with window entry len-1-i (entry 0 is newest).
   always_comb begin
      mismatch = 1'b0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (i < int'(len)) begin
            if (window[IDX_W'(int'(len) - 1 - i)] != cpm_fold(pattern[8*i +: 8])) begin
               mismatch = 1'b1;
            end
         end
      end
      equal = !mismatch;
   end

endmodule

>>> design/caseless_pattern_match_positions_unit.sv
// ----------------------------------------------------------------------------
// caseless_pattern_match_positions_unit
// Streaming caseless search for a pattern of up to 16 bytes in a buffer.
// ----------------------------------------------------------------------------
// The unit takes one buffer byte per req transaction and returns at most one
// rsp transaction per byte. A byte flagged first_byte starts a new buffer at
// offset 0; each byte of an active scan then yields a response that tells
// whether the byte completes a non-overlapping, ASCII case-insensitive match
// of the configured pattern, where that match starts, whether the scan ends
// here and how many matches the buffer has had so far. The scan ends at a
// zero byte, at the byte flagged last_byte, or once match_limit matches have
// been reported; later bytes produce no response until the next first_byte.
// A zero pattern length or a zero limit ends the scan at its first byte with
// a count of zero. Throughput is one byte per clock unless stalled: the
// 16-byte window compare sits between the input register and the result
// register; a byte passes through both in turn, and the scan state is
// updated in the same cycle the byte moves into the result register.
// req ready follows rsp ready through the result register, so the unit
// stalls only when a response waits and the result side is not taking it.
// Configuration must be written while no byte is in flight.
module caseless_pattern_match_positions_unit #(
   parameter int unsigned PATTERN_MAX = 16,
   parameter int unsigned OFFSET_BITS = 20
) (
   input  logic     clock,
   input  logic     reset,
   cpm_req_if.sink   req_ch,
   cpm_rsp_if.source rsp_ch,
   cpm_csr_if.sink   csr_ch
);
   import cpm_pkg::*;

   localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);

   // Configuration registers.
   cpm_cfg_type cfg;

   cpm_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .cfg   (cfg)
   );

   // Input register stage.
   logic              in_valid_ff, in_valid_in;
   logic [TEXT_W-1:0] in_text_ff;
   logic              in_first_ff;
   logic              in_last_ff;

   // Scan state.
   logic [PATTERN_MAX-1:0][7:0] window_ff, window_in;
   logic [LEN_W-1:0]            since_ff, since_in;
   logic [OFFSET_BITS-1:0]      offset_ff, offset_in;
   logic [LIMIT_W-1:0]          count_ff, count_in;
   logic                        active_ff, active_in;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic              found_ff, found_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              done_ff, done_in;
   logic [LIMIT_W-1:0] total_ff, total_in;

   logic out_free;
   logic advance;
   logic has_result;

   // Working values for the byte in the input register.
   logic [TEXT_W-1:0]           folded;
   logic [LEN_W-1:0]            len_used;
   logic                        empty_search;
   logic [PATTERN_MAX-1:0][7:0] base_window;
   logic [PATTERN_MAX-1:0][7:0] shifted_window;
   logic [LEN_W-1:0]            base_since;
   logic [LEN_W-1:0]            inc_since;
   logic [OFFSET_BITS-1:0]      base_offset;
   logic [LIMIT_W-1:0]          base_count;
   logic [LIMIT_W-1:0]          next_count;
   logic                        base_active;
   logic                        window_equal;
   logic                        is_match;
   logic                        end_scan;
   logic [OFFSET_BITS-1:0]      start_offset;
   logic [31:0]                 start_wide;

   // The result register is free when empty or being taken this cycle.
   assign out_free      = !rsp_valid_ff || rsp_ch.ready;
   assign advance       = in_valid_ff && out_free;
   assign req_ch.ready  = !in_valid_ff || out_free;

   assign folded   = cpm_fold(in_text_ff);
   assign len_used = (cfg.pattern_length > LENREG_W'(PATTERN_MAX))
                     ? LEN_W'(PATTERN_MAX) : LEN_W'(cfg.pattern_length);
   assign empty_search = (len_used == '0) || (cfg.match_limit == '0);

   // A first byte starts from a cleared state.
   always_comb begin
      if (in_first_ff) begin
         base_window = '0;
         base_since  = '0;
         base_offset = '0;
         base_count  = '0;
         base_active = 1'b1;
      end else begin
         base_window = window_ff;
         base_since  = since_ff;
         base_offset = offset_ff;
         base_count  = count_ff;
         base_active = active_ff;
      end
   end

   // Newest byte enters at entry 0.
   always_comb begin
      shifted_window[0] = folded;
      for (int i = 1; i < PATTERN_MAX; i++) begin
         shifted_window[i] = base_window[i-1];
      end
   end

   assign inc_since = (base_since < LEN_W'(PATTERN_MAX)) ? base_since + 1'b1 : base_since;

   cpm_window_cmp #(
      .PATTERN_MAX (PATTERN_MAX),
      .LEN_W       (LEN_W)
   ) u_cmp (
      .window  (shifted_window),
      .pattern (cfg.pattern),
      .len     (len_used),
      .equal   (window_equal)
   );

   assign is_match     = (inc_since >= len_used) && window_equal;
   assign next_count   = is_match ? base_count + 1'b1 : base_count;
   assign end_scan     = in_last_ff || (next_count >= cfg.match_limit);
   assign start_offset = base_offset - OFFSET_BITS'(len_used) + 1'b1;
   assign start_wide   = 32'(start_offset);

   // Next state and result for the byte leaving the input register.
   always_comb begin
      window_in  = window_ff;
      since_in   = since_ff;
      offset_in  = offset_ff;
      count_in   = count_ff;
      active_in  = active_ff;
      has_result = 1'b0;
      found_in   = 1'b0;
      pos_in     = '0;
      done_in    = 1'b0;
      total_in   = '0;
      if (advance) begin
         window_in = base_window;
         since_in  = base_since;
         offset_in = base_offset;
         count_in  = base_count;
         active_in = base_active;
         if (in_first_ff && empty_search) begin
            // Nothing to search for: the scan ends at once.
            active_in  = 1'b0;
            has_result = 1'b1;
            done_in    = 1'b1;
         end else if (base_active) begin
            has_result = 1'b1;
            if (in_text_ff == NUL_CHAR) begin
               // A NUL byte ends the scan and never joins a match.
               active_in = 1'b0;
               done_in   = 1'b1;
               total_in  = base_count;
            end else begin
               window_in = shifted_window;
               since_in  = is_match ? '0 : inc_since;
               count_in  = next_count;
               offset_in = base_offset + 1'b1;
               active_in = !end_scan;
               found_in  = is_match;
               pos_in    = is_match ? start_wide[POS_W-1:0] : '0;
               done_in   = end_scan;
               total_in  = next_count;
            end
         end
      end
   end

   always_comb begin
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = has_result;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= '0;
         since_ff     <= '0;
         offset_ff    <= '0;
         count_ff     <= '0;
         active_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         window_ff    <= window_in;
         since_ff     <= since_in;
         offset_ff    <= offset_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_text_ff  <= req_ch.text_byte;
         in_first_ff <= req_ch.first_byte;
         in_last_ff  <= req_ch.last_byte;
      end
      if (advance && has_result) begin
         found_ff <= found_in;
         pos_ff   <= pos_in;
         done_ff  <= done_in;
         total_ff <= total_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.match_found    = found_ff;
   assign rsp_ch.match_position = pos_ff;
   assign rsp_ch.scan_done      = done_ff;
   assign rsp_ch.match_total    = total_ff;

endmodule

>>> design/cpm_checker.sv
// ----------------------------------------------------------------------------
// cpm_checker
// Port-level checks of the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module cpm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        match_found,
   input logic [19:0] match_position,
   input logic [15:0] match_total
);

   // A response that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A reported match is counted in the running total.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && match_found |-> match_total != 16'd0)
      else $error("match reported with zero total");

   // Without a match the position reads zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !match_found |-> match_position == 20'd0)
      else $error("position set without a match");

   // No response is offered right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind caseless_pattern_match_positions_unit cpm_checker u_cpm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .match_found    (rsp_ch.match_found),
   .match_position (rsp_ch.match_position),
   .match_total    (rsp_ch.match_total)
);
